// File: sv/psr_pkg.sv
// package for the perfect shuffle rounds block: types and fixed widths
`timescale 1ns / 1ps
package psr_pkg;

  localparam int CARD_W     = 32;
  localparam int HALF_CFG_W = 6;
  localparam int ROUND_W    = 8;
  localparam int LOAD_CNT_W = 7;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_SIZE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROUND_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SHUF,
    ST_EMIT
  } psr_state_t;

endpackage

// File: sv/perfect_shuffle_rounds.sv
// top level of the perfect shuffle rounds block: loader, shuffle sequencer, emitter
`timescale 1ns / 1ps
// perfect out-shuffle (faro) engine
// - input channel (in_valid / in_ready / in_card_word): one card per transaction,
//   top of deck first; a deck holds 2n cards, n taken from the half_size register
// - config port (cfg_wr_en / cfg_index / cfg_data): index 0 half_size, 1 round_count;
//   half_size of 0 acts as 1, above HALF_MAX acts as HALF_MAX
// - the card that completes the deck starts round_count shuffle rounds; each round
//   streams the deck through one memory read port into the other bank,
//   one card a cycle
// - emission reads the final bank top first; a card is read only once the previous
//   one has reached the output register and the receiver keeps up (read, then
//   output register); out_is_last flags the last card
// - in_ready is high only while loading; the next deck may start while the last
//   result still sits in the output register
// - a stalled receiver holds the output register and the emitter waits
// - reset (rst_n low, synchronous) empties the deck count and sets half_size and
//   round_count to 1; the card banks are not cleared, no clearing pass is needed
module perfect_shuffle_rounds
  import psr_pkg::*;
#(
  parameter int HALF_MAX = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CARD_W-1:0]     in_card_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CARD_W-1:0]     out_card_out,
  output logic                  out_is_last,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = 2 * HALF_MAX;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [HALF_CFG_W-1:0] HALF_MAX_W = HALF_CFG_W'(HALF_MAX);

  // configuration registers
  logic [HALF_CFG_W-1:0] half_size_r;
  logic [ROUND_W-1:0]    round_count_r;

  // sequencer state
  psr_state_t           state_r, state_nxt;
  logic [LOAD_CNT_W-1:0] load_count_r, load_count_nxt;
  logic [AW-1:0]        k_r, k_nxt;          // position within the current pass
  logic [ROUND_W-1:0]   rnd_r, rnd_nxt;      // rounds still to run
  logic                 src_sel_r, src_sel_nxt; // 0: bank a holds the current deck

  // read port control
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 rd_sel_r;            // bank the registered read came from

  // write-back of a shuffle read, in the cycle after its read
  logic                 wr_pend_r;
  logic [AW-1:0]        wr_addr_r;
  logic                 wr_to_b_r;
  logic                 shuf_issue;

  // emission
  logic                 emit_issue;
  logic                 emit_pend_r;
  logic                 emit_last_r;
  logic                 out_valid_r;
  logic [CARD_W-1:0]    out_card_r;
  logic                 out_last_r;

  // card banks
  logic [CARD_W-1:0]    mem_a [DEPTH];
  logic [CARD_W-1:0]    mem_b [DEPTH];
  logic [CARD_W-1:0]    rdata_a_r;
  logic [CARD_W-1:0]    rdata_b_r;
  logic [CARD_W-1:0]    rdata;

  // deck geometry
  logic [HALF_CFG_W-1:0] half_eff6;
  logic [AW-1:0]         half_eff;
  logic [AW:0]           total;
  logic                  last_pos;
  logic                  load_done;
  logic                  in_fire;

  always_comb begin
    if (half_size_r == '0) begin
      half_eff6 = HALF_CFG_W'(1);
    end else if (half_size_r > HALF_MAX_W) begin
      half_eff6 = HALF_MAX_W;
    end else begin
      half_eff6 = half_size_r;
    end
  end

  assign half_eff  = AW'(half_eff6);
  assign total     = {1'b0, half_eff} << 1;
  assign last_pos  = ({1'b0, k_r} == (total - (AW+1)'(1)));
  assign in_ready  = (state_r == ST_LOAD);
  assign in_fire   = in_valid && in_ready;
  assign load_done = (LOAD_CNT_W'(load_count_r + LOAD_CNT_W'(1)) >=
                      LOAD_CNT_W'(total));
  assign rdata     = rd_sel_r ? rdata_b_r : rdata_a_r;

  // config writes, taken any time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_size_r   <= HALF_CFG_W'(1);
      round_count_r <= ROUND_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_HALF_SIZE:   half_size_r   <= cfg_data[HALF_CFG_W-1:0];
        REG_ROUND_COUNT: round_count_r <= cfg_data[ROUND_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: next state and read port control
  always_comb begin
    state_nxt      = state_r;
    load_count_nxt = load_count_r;
    k_nxt          = k_r;
    rnd_nxt        = rnd_r;
    src_sel_nxt    = src_sel_r;
    rd_en          = 1'b0;
    rd_addr        = k_r;
    shuf_issue     = 1'b0;
    emit_issue     = 1'b0;
    case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          if (load_done) begin
            load_count_nxt = '0;
            k_nxt          = '0;
            src_sel_nxt    = 1'b0;
            rnd_nxt        = round_count_r;
            state_nxt      = (round_count_r == '0) ? ST_EMIT : ST_SHUF;
          end else begin
            load_count_nxt = LOAD_CNT_W'(load_count_r + LOAD_CNT_W'(1));
          end
        end
      end
      ST_SHUF: begin
        // even slots take the top half, odd slots the bottom half
        rd_en      = 1'b1;
        shuf_issue = 1'b1;
        rd_addr    = k_r[0] ? AW'(half_eff + (k_r >> 1)) : (k_r >> 1);
        if (last_pos) begin
          k_nxt       = '0;
          src_sel_nxt = ~src_sel_r;
          rnd_nxt     = ROUND_W'(rnd_r - ROUND_W'(1));
          if (rnd_r == ROUND_W'(1)) begin
            state_nxt = ST_EMIT;
          end
        end else begin
          k_nxt = AW'(k_r + AW'(1));
        end
      end
      ST_EMIT: begin
        if (!emit_pend_r && (!out_valid_r || out_ready)) begin
          rd_en      = 1'b1;
          emit_issue = 1'b1;
          rd_addr    = k_r;
          if (last_pos) begin
            k_nxt     = '0;
            state_nxt = ST_LOAD;
          end else begin
            k_nxt = AW'(k_r + AW'(1));
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      load_count_r <= '0;
      k_r          <= '0;
      rnd_r        <= '0;
      src_sel_r    <= 1'b0;
      wr_pend_r    <= 1'b0;
      emit_pend_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      load_count_r <= load_count_nxt;
      k_r          <= k_nxt;
      rnd_r        <= rnd_nxt;
      src_sel_r    <= src_sel_nxt;
      wr_pend_r    <= shuf_issue;
      emit_pend_r  <= emit_issue;
      if (emit_pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload side registers, no reset needed
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_sel_r <= src_sel_r;
    end
    if (shuf_issue) begin
      wr_addr_r <= k_r;
      wr_to_b_r <= ~src_sel_r;
    end
    if (emit_issue) begin
      emit_last_r <= last_pos;
    end
    if (emit_pend_r) begin
      out_card_r <= rdata;
      out_last_r <= emit_last_r;
    end
  end

  // bank a: loaded by the input channel, also a shuffle target
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem_a[load_count_r[AW-1:0]] <= in_card_word;
    end else if (wr_pend_r && !wr_to_b_r) begin
      mem_a[wr_addr_r] <= rdata;
    end
    if (rd_en) begin
      rdata_a_r <= mem_a[rd_addr];
    end
  end

  // bank b: shuffle target only
  always_ff @(posedge clk) begin
    if (wr_pend_r && wr_to_b_r) begin
      mem_b[wr_addr_r] <= rdata;
    end
    if (rd_en) begin
      rdata_b_r <= mem_b[rd_addr];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_card_out = out_card_r;
  assign out_is_last  = out_last_r;

`ifndef SYNTHESIS
  // a read for emission always lands in a free output register
  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit_pend_r |-> !out_valid_r)
    else $error("emission read landed on a full output register");

  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    emit_pend_r |=> out_valid_r)
    else $error("emission read was lost");

  // shuffle write-back never overlaps loading of a new deck
  a_wb_not_loading: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> (state_r == ST_SHUF || state_r == ST_EMIT))
    else $error("shuffle write-back while loading");
`endif

endmodule

// File: sim/testbench.sv
// testbench for the perfect shuffle rounds block: random decks checked against a shuffle predictor
`timescale 1ns / 1ps
module testbench
  import psr_pkg::*;
();

  localparam int HALF_MAX     = 32;
  localparam int BANK_DEPTH   = 2 * HALF_MAX;
  localparam int SETTLE_TICKS = 16;       // quiet cycles before a register write or the end
  localparam int LONG_HOLD    = 300;      // receiver hold-off that backs the block up
  localparam int LIMIT_CYCLES = 800_000;  // watchdog limit for the whole run
  localparam int RANDOM_CARDS = 130;

  // one card of a shuffled deck as it should come out
  typedef struct packed {
    logic [CARD_W-1:0] card;
    logic              last;
  } shuffled_card_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CARD_W-1:0]     in_card_word = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CARD_W-1:0]     out_card_out;
  logic                  out_is_last;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_HALF_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // pending cards for the driver, and shuffled cards still owed by the block
  logic [CARD_W-1:0] card_queue [$];
  shuffled_card_t    shuffled_due [$];

  // predictor state: two card banks, load position and register copies
  logic [CARD_W-1:0]     card_bank [2][BANK_DEPTH];
  logic [LOAD_CNT_W-1:0] cards_loaded = '0;
  logic [HALF_CFG_W-1:0] half_reg = 6'd1;
  logic [ROUND_W-1:0]    round_reg = 8'd1;

  bit          burst_mode = 1'b0;  // both sides draw no random gaps while set
  int unsigned in_gap = 0;
  int unsigned out_wait = 0;
  int unsigned hold_left = 0;
  int unsigned holds_done = 0;
  int unsigned err_count = 0;
  int unsigned checked_count = 0;
  int unsigned cycle_count = 0;

  perfect_shuffle_rounds #(
    .HALF_MAX(HALF_MAX)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_card_word(in_card_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_card_out(out_card_out),
    .out_is_last (out_is_last),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // idle cycles before the next transaction on either side
  function automatic int unsigned draw_gap();
    return burst_mode ? 0 : $urandom_range(0, 7);
  endfunction

  // half size in force: zero acts as one, anything past the maximum is clamped
  function automatic int unsigned active_half();
    if (half_reg == 0) return 1;
    if (half_reg > HALF_MAX) return HALF_MAX;
    return half_reg;
  endfunction

  // append one card to the driver's queue
  task automatic queue_card(input logic [CARD_W-1:0] card);
    card_queue.insert(card_queue.size(), card);
  endtask

  // store one accepted card; the card that fills the deck shuffles it and
  // queues the whole shuffled deck, top first, last card flagged
  task automatic take_card(input logic [CARD_W-1:0] card);
    int unsigned    h;
    int unsigned    total;
    int unsigned    r;
    int unsigned    i;
    bit             side;
    shuffled_card_t due;
    h     = active_half();
    total = 2 * h;
    card_bank[0][cards_loaded[5:0]] = card;
    cards_loaded = cards_loaded + 1'b1;
    if (cards_loaded < total) return;
    cards_loaded = '0;
    side = 1'b0;
    for (r = 0; r < round_reg; r++) begin
      // out-shuffle: top half goes to even slots, bottom half to odd slots
      for (i = 0; i < h; i++) begin
        card_bank[!side][2*i]   = card_bank[side][i];
        card_bank[!side][2*i+1] = card_bank[side][h+i];
      end
      side = !side;
    end
    for (i = 0; i < total; i++) begin
      due.card = card_bank[side][i];
      due.last = (i + 1 == total);
      shuffled_due.insert(shuffled_due.size(), due);
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    err_count++;
  endtask

  // register write; only called while the block is quiet
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_HALF_SIZE) half_reg = val[HALF_CFG_W-1:0];
    else round_reg = val[ROUND_W-1:0];
  endtask

  // wait until every card is sent and every shuffled card is back, then let
  // the block run down; sampled at the falling edge to stay clear of updates
  task automatic settle();
    @(negedge clk);
    while (card_queue.size() != 0 || in_valid || shuffled_due.size() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic queue_random_cards(input int unsigned count);
    int unsigned i;
    for (i = 0; i < count; i++) queue_card($urandom);
  endtask

  // driver: one card per transaction, a fresh gap drawn for every card
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (card_queue.size() != 0) begin
        in_valid     <= 1'b1;
        in_card_word <= card_queue.pop_front();
        in_gap       <= draw_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks each result transaction against the oldest owed card,
  // feeds accepted cards to the predictor and paces out_ready
  always @(posedge clk) begin : monitor
    shuffled_card_t due;
    int unsigned    w;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_wait  <= 0;
      hold_left <= 0;
    end else begin
      // results are checked before this edge's card is predicted
      if (out_valid && out_ready) begin
        if (shuffled_due.size() == 0) begin
          report_mismatch($sformatf("unexpected card %h (last %b)", out_card_out, out_is_last));
        end else begin
          due = shuffled_due.pop_front();
          if (out_card_out !== due.card)
            report_mismatch($sformatf("card %0d: got %h, want %h",
                                      checked_count, out_card_out, due.card));
          if (out_is_last !== due.last)
            report_mismatch($sformatf("card %0d: last flag %b, want %b",
                                      checked_count, out_is_last, due.last));
        end
        checked_count++;
      end
      if (in_valid && in_ready) take_card(in_card_word);

      // ready pacing; a long hold-off while the sender still has cards lets
      // the block fill up and stall its input
      if (out_valid && out_ready) begin
        if (holds_done < 2 && (in_valid || card_queue.size() != 0)) begin
          hold_left  <= LONG_HOLD;
          holds_done <= holds_done + 1;
          out_ready  <= 1'b0;
        end else begin
          w = draw_gap();
          out_wait  <= w;
          out_ready <= (w == 0);
        end
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= (hold_left == 1);
      end else if (out_wait != 0) begin
        out_wait  <= out_wait - 1;
        out_ready <= (out_wait == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned    rand_items;
    int unsigned    decks;
    int unsigned    tail;
    int unsigned    n;
    int unsigned    i;
    int unsigned    phase;
    logic [7:0]     half_val;
    logic [7:0]     round_val;
    bit             big_done;
    rand_items = 0;
    phase      = 0;
    big_done   = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: two-card deck, one round, field extremes
    queue_card(32'h0000_0000);
    queue_card(32'hFFFF_FFFF);
    settle();

    // half size zero acts as one, zero rounds pass the deck through
    write_reg(REG_HALF_SIZE, 8'd0);
    write_reg(REG_ROUND_COUNT, 8'd0);
    queue_card(32'hAAAA_AAAA);
    queue_card(32'h5555_5555);
    settle();

    // upper data bits dropped (half size 3), maximum round count
    write_reg(REG_HALF_SIZE, 8'hC3);
    write_reg(REG_ROUND_COUNT, 8'd255);
    for (i = 0; i < 6; i++) queue_card(32'h1111_1111 * (i + 1));
    settle();

    // deck shrinks mid-load: the next card completes the smaller deck
    write_reg(REG_HALF_SIZE, 8'd2);
    write_reg(REG_ROUND_COUNT, 8'd3);
    queue_random_cards(3);
    settle();
    write_reg(REG_HALF_SIZE, 8'd1);
    queue_random_cards(1);
    settle();

    // deck grows mid-load: loading carries on to the new size
    write_reg(REG_ROUND_COUNT, 8'd2);
    queue_random_cards(1);
    settle();
    write_reg(REG_HALF_SIZE, 8'd2);
    queue_random_cards(3);

    // random phases: mostly small decks, back to back, sometimes a partial
    // deck left behind for the next setting to pick up
    while (rand_items < RANDOM_CARDS) begin
      settle();
      burst_mode = ($urandom_range(0, 3) == 0);
      if (!big_done && rand_items >= 60) begin
        // largest deck: exact maximum, then a value past it
        write_reg(REG_HALF_SIZE, 8'd32);
        write_reg(REG_HALF_SIZE, 8'hFF);
        round_val = $urandom_range(0, 1) ? 8'd255 : 8'($urandom_range(1, 254));
        write_reg(REG_ROUND_COUNT, round_val);
        queue_random_cards(2 * HALF_MAX);
        rand_items += 2 * HALF_MAX;
        big_done = 1'b1;
      end else begin
        half_val = 8'($urandom_range(0, 3) * 64 + $urandom_range(0, 6));
        case ($urandom_range(0, 3))
          0:       round_val = 8'd0;
          1:       round_val = 8'd255;
          default: round_val = 8'($urandom_range(0, 255));
        endcase
        write_reg(REG_HALF_SIZE, half_val);
        write_reg(REG_ROUND_COUNT, round_val);
        n     = (half_val[5:0] == 0) ? 1 : half_val[5:0];
        decks = (phase == 0) ? 3 : $urandom_range(1, 3);
        tail  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2 * n - 1) : 0;
        if (n == 1) tail = tail % 2;
        queue_random_cards(decks * 2 * n + tail);
        rand_items += decks * 2 * n + tail;
      end
      phase++;
    end

    settle();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
